FILE: rtl/core/dsf64_pkg.sv
// ----------------------------------------------------------------------------
// dsf64_pkg: shared types and constants
// Command codes, result kinds, controller states and the P-array start values
// of the dynamic S-box Feistel engine.
// ----------------------------------------------------------------------------
package dsf64_pkg;

    localparam int DEF_BOX_DEPTH = 2048;
    localparam int DEF_ROUNDS    = 16;
    localparam int NUM_BOXES     = 4;
    localparam int KEY_WORDS     = 8;
    localparam int P_DEPTH       = 18;
    localparam int WORDS_W       = 12;
    localparam logic [WORDS_W-1:0] WORDS_RESET = 12'd2048;

    typedef enum logic [2:0] {
        CMD_LOAD_SBOX = 3'd0,
        CMD_LOAD_P    = 3'd1,
        CMD_LOAD_KEY  = 3'd2,
        CMD_LOAD_DATA = 3'd3,
        CMD_EXPAND    = 3'd4,
        CMD_ENCIPHER  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_LOAD_ACK = 2'd0,
        KIND_EXPANDED = 2'd1,
        KIND_BLOCK    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MODE_ENC   = 2'd0,
        MODE_XP    = 2'd1,
        MODE_XS    = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEYMIX,
        ST_XDATA,
        ST_HALF,
        ST_MOD,
        ST_READ,
        ST_FINAL,
        ST_STORE_L,
        ST_STORE_R,
        ST_DONE
    } t_state;

    typedef logic [63:0] t_word;

    localparam t_word P_INIT [P_DEPTH] = '{
        64'h243f6a8885a308d3, 64'h13198a2e03707344, 64'ha4093822299f31d0,
        64'h082efa98ec4e6c89, 64'h452821e638d01377, 64'hbe5466cf34e90c6c,
        64'hc0ac29b7c97c50dd, 64'h3f84d5b5b5470917, 64'h9216d5d98979fb1b,
        64'hd1310ba698dfb5ac, 64'h2ffd72dbd01adfb7, 64'hb8e1afed6a267e96,
        64'hba7c9045f12c7f99, 64'h24a19947b3916cf7, 64'h0801f2e2858efc16,
        64'h636920d871574e69, 64'ha458fea3f4933d7e, 64'h0d95748f728eb658
    };

    // Right rotation amount applied to the round input for each S-box.
    localparam logic [5:0] ROT_AMT [NUM_BOXES] = '{6'd61, 6'd22, 6'd53, 6'd33};

    function automatic t_word rot_right(input t_word v, input logic [5:0] n);
        logic [127:0] dbl;
        dbl = {v, v} >> n;
        return dbl[63:0];
    endfunction

endpackage

FILE: rtl/core/dynamic_sbox_feistel64_engine_unit.sv
// ----------------------------------------------------------------------------
// dynamic_sbox_feistel64_engine_unit
// Feistel engine with four run-time sized S-boxes held in one synchronous RAM.
// ----------------------------------------------------------------------------
// Sequencing: a load is written when accepted and its acknowledge is registered in the
// done state. Each half-round runs a setup state, the remainder state and the read state
// for the four RAM reads; an encipher runs all half-rounds and then the final whitening.
// Expand: key mix, then a data XOR and a full encipher per P word pair and per S-box word pair.
// One transaction at a time: the command channel stalls until the engine is idle again.
// Reset (synchronous, active low) restores P, clears key/data, state.
module dynamic_sbox_feistel64_engine_unit
    import dsf64_pkg::*;
#(
    parameter int BOX_DEPTH = DEF_BOX_DEPTH,
    parameter int ROUNDS    = DEF_ROUNDS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration port: active word count per S-box.
    input  logic                i_cfg_we,
    input  logic [WORDS_W-1:0]  i_cfg_wdata,
    // Command channel.
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_cmd,
    input  logic [1:0]          i_box_select,
    input  logic [10:0]         i_word_index,
    input  logic [63:0]         i_word_value,
    input  logic [63:0]         i_block_left,
    input  logic [63:0]         i_block_right,
    // Result channel.
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_result_kind,
    output logic [63:0]         o_out_left,
    output logic [63:0]         o_out_right
);

    localparam int ABW    = $clog2(BOX_DEPTH);
    localparam int MAW    = ABW + 2;
    localparam int NHALF  = 2 * ((ROUNDS + 1) / 2);
    localparam int PCOUNT = ROUNDS + 2;
    localparam logic [16:0] DEPTH17 = 17'(BOX_DEPTH);
    localparam logic [16:0] MAXW17  = 17'(BOX_DEPTH) & ~17'd1;

    // The S-box RAM. Each box occupies a power-of-two slice; words past the
    // depth are never addressed.
    t_word m_sbox [NUM_BOXES << ABW];

    t_state r_state, n_state;
    t_mode  r_mode;
    t_kind  r_res_kind;

    t_word  r_p    [P_DEPTH];
    t_word  r_key  [KEY_WORDS];
    t_word  r_data [KEY_WORDS];
    logic [WORDS_W-1:0] r_words;

    t_word  r_l, r_r, r_h, r_rdata;
    t_word  r_mv  [NUM_BOXES];
    logic [WORDS_W-1:0] r_rem [NUM_BOXES];
    logic [3:0]  r_cnt;
    logic [2:0]  r_rd;
    logic [4:0]  r_half;
    logic [4:0]  r_pi;
    logic [WORDS_W-1:0] r_j;
    logic [1:0]  r_box;

    logic        r_out_valid;
    logic [1:0]  r_out_kind;
    t_word       r_out_left, r_out_right;

    logic [WORDS_W-1:0] w_act;
    logic        in_acc;
    logic        mem_we;
    logic [MAW-1:0] mem_waddr, mem_raddr;
    t_word       mem_wdata;
    logic        half_last, xp_last, xs_row_last;
    t_word       x_half, f_val, xdat;

    // Active word count: even, at least two, at most the box depth.
    always_comb begin
        logic [16:0] w17;
        w17 = {5'd0, r_words & 12'hFFE};
        if (w17 == 17'd0) begin
            w17 = 17'd2;
        end
        if (w17 > DEPTH17) begin
            w17 = MAXW17;
        end
        w_act = w17[WORDS_W-1:0];
    end

    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign half_last   = (r_half == 5'(NHALF - 1));
    assign xp_last     = ((6'(r_pi) + 6'd2) >= 6'(PCOUNT));
    assign xs_row_last = ((13'(r_j) + 13'd3) >= 13'(w_act));
    assign x_half      = (r_half[0] ? r_r : r_l) ^ r_p[r_half];
    assign f_val       = r_h + r_rdata;
    assign xdat        = (r_mode == MODE_XP) ? r_data[r_pi[2:0]] : r_data[r_j[2:0]];

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_cmd)
                        CMD_EXPAND:   n_state = ST_KEYMIX;
                        CMD_ENCIPHER: n_state = ST_HALF;
                        default:      n_state = ST_DONE;
                    endcase
                end
            end
            ST_KEYMIX:  n_state = ST_XDATA;
            ST_XDATA:   n_state = ST_HALF;
            ST_HALF:    n_state = ST_MOD;
            ST_MOD:     n_state = (r_cnt == 4'd15) ? ST_READ : ST_MOD;
            ST_READ: begin
                if (r_rd == 3'd4) begin
                    n_state = half_last ? ST_FINAL : ST_HALF;
                end
            end
            ST_FINAL: begin
                case (r_mode)
                    MODE_ENC: n_state = ST_DONE;
                    MODE_XP:  n_state = ST_XDATA;
                    default:  n_state = ST_STORE_L;
                endcase
            end
            ST_STORE_L: n_state = ST_STORE_R;
            ST_STORE_R: begin
                n_state = (xs_row_last && r_box == 2'(NUM_BOXES - 1)) ? ST_DONE : ST_XDATA;
            end
            ST_DONE:    n_state = (!r_out_valid || !i_out_stall) ? ST_IDLE : ST_DONE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Output and RAM port control.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = {i_box_select, ABW'(i_word_index)};
        mem_wdata = i_word_value;
        mem_raddr = {r_rd[1:0], ABW'(r_rem[r_rd[1:0]])};
        case (r_state)
            ST_IDLE: begin
                mem_we = in_acc && (i_cmd == CMD_LOAD_SBOX) &&
                         ({6'd0, i_word_index} < DEPTH17);
            end
            ST_STORE_L: begin
                mem_we    = 1'b1;
                mem_waddr = {r_box, ABW'(r_j)};
                mem_wdata = r_l;
            end
            ST_STORE_R: begin
                mem_we    = 1'b1;
                mem_waddr = {r_box, ABW'(r_j | 12'd1)};
                mem_wdata = r_r;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_out_left    = r_out_left;
    assign o_out_right   = r_out_right;

    // S-box RAM: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_sbox[mem_waddr] <= mem_wdata;
        end
        r_rdata <= m_sbox[mem_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Architectural state with defined reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= WORDS_RESET;
            for (int i = 0; i < P_DEPTH; i++) begin
                r_p[i] <= P_INIT[i];
            end
            for (int i = 0; i < KEY_WORDS; i++) begin
                r_key[i]  <= '0;
                r_data[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_words <= i_cfg_wdata;
            end
            if (in_acc && i_cmd == CMD_LOAD_P && i_word_index < 11'(P_DEPTH)) begin
                r_p[i_word_index[4:0]] <= i_word_value;
            end
            if (in_acc && i_cmd == CMD_LOAD_KEY && i_word_index < 11'(KEY_WORDS)) begin
                r_key[i_word_index[2:0]] <= i_word_value;
            end
            if (in_acc && i_cmd == CMD_LOAD_DATA && i_word_index < 11'(KEY_WORDS)) begin
                r_data[i_word_index[2:0]] <= i_word_value;
            end
            if (r_state == ST_KEYMIX) begin
                for (int i = 0; i < PCOUNT; i++) begin
                    r_p[i] <= r_p[i] ^ r_key[i % KEY_WORDS];
                end
            end
            if (r_state == ST_FINAL && r_mode == MODE_XP) begin
                r_p[r_pi]        <= r_r ^ r_p[PCOUNT - 1];
                r_p[r_pi + 5'd1] <= r_l ^ r_p[PCOUNT - 2];
            end
        end
    end

    // Datapath: half-rounds, remainder units and expand sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENC;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_res_kind <= (in_acc && i_cmd == CMD_ENCIPHER) ? KIND_BLOCK
                                                                     : KIND_LOAD_ACK;
                    r_l        <= i_block_left;
                    r_r        <= i_block_right;
                    r_half     <= '0;
                    if (in_acc && i_cmd == CMD_EXPAND) begin
                        r_mode <= MODE_XP;
                    end else if (in_acc) begin
                        r_mode <= MODE_ENC;
                    end
                end
                ST_KEYMIX: begin
                    r_l  <= '0;
                    r_r  <= '0;
                    r_pi <= '0;
                    r_j  <= '0;
                    r_box <= '0;
                end
                ST_XDATA: begin
                    r_l    <= r_l ^ xdat;
                    r_r    <= r_r ^ xdat;
                    r_half <= '0;
                end
                ST_HALF: begin
                    if (r_half[0]) begin
                        r_r <= x_half;
                    end else begin
                        r_l <= x_half;
                    end
                    for (int b = 0; b < NUM_BOXES; b++) begin
                        r_mv[b]  <= rot_right(x_half, ROT_AMT[b]);
                        r_rem[b] <= '0;
                    end
                    r_cnt <= '0;
                    r_rd  <= '0;
                end
                ST_MOD: begin
                    // Four restoring remainder steps per box per cycle.
                    for (int b = 0; b < NUM_BOXES; b++) begin
                        logic [WORDS_W:0]   t;
                        logic [WORDS_W-1:0] rm;
                        rm = r_rem[b];
                        for (int s = 0; s < 4; s++) begin
                            t = {rm, r_mv[b][63 - s]};
                            if (t >= {1'b0, w_act}) begin
                                t = t - {1'b0, w_act};
                            end
                            rm = t[WORDS_W-1:0];
                        end
                        r_rem[b] <= rm;
                        r_mv[b]  <= r_mv[b] << 4;
                    end
                    r_cnt <= r_cnt + 4'd1;
                end
                ST_READ: begin
                    r_rd <= r_rd + 3'd1;
                    case (r_rd)
                        3'd1: r_h <= r_rdata;
                        3'd2: r_h <= r_h + r_rdata;
                        3'd3: r_h <= r_h ^ r_rdata;
                        3'd4: begin
                            if (r_half[0]) begin
                                r_l <= r_l ^ f_val;
                            end else begin
                                r_r <= r_r ^ f_val;
                            end
                            r_half <= r_half + 5'd1;
                        end
                        default: r_h <= r_h;
                    endcase
                end
                ST_FINAL: begin
                    // Undo the last swap and apply the output whitening.
                    r_l <= r_r ^ r_p[PCOUNT - 1];
                    r_r <= r_l ^ r_p[PCOUNT - 2];
                    if (r_mode == MODE_XP) begin
                        r_pi <= r_pi + 5'd2;
                        if (xp_last) begin
                            r_mode <= MODE_XS;
                        end
                    end
                end
                ST_STORE_R: begin
                    if (xs_row_last) begin
                        r_j   <= '0;
                        r_box <= r_box + 2'd1;
                    end else begin
                        r_j <= r_j + 12'd2;
                    end
                    r_res_kind <= KIND_EXPANDED;
                end
                ST_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_kind  <= r_res_kind;
                        r_out_left  <= (r_res_kind == KIND_BLOCK) ? r_l : '0;
                        r_out_right <= (r_res_kind == KIND_BLOCK) ? r_r : '0;
                    end
                end
                default: begin
                    r_h <= r_h;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_no_write_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> !mem_we)
        else $error("S-box RAM written during a round read");

    a_mod_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOD && r_cnt == 4'd15) |=> (r_state == ST_READ))
        else $error("remainder sequence did not hand over to the reads");

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_rem[0] < w_act && r_rem[1] < w_act &&
                                  r_rem[2] < w_act && r_rem[3] < w_act))
        else $error("S-box index at or beyond the active word count");

    a_zero_halves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != KIND_BLOCK) |->
        (r_out_left == '0 && r_out_right == '0))
        else $error("nonzero halves on a non-block result");
`endif

endmodule

FILE: tb/dsf64_result_checker.sv
// ----------------------------------------------------------------------------
// dsf64_result_checker
// Watches the command, result and configuration ports of the Feistel engine.
// It keeps a private copy of P, S-boxes, key and data words, and predicts each
// result in order.
// ----------------------------------------------------------------------------
module dsf64_result_checker
    import dsf64_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [WORDS_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [2:0]         i_cmd,
    input  logic [1:0]         i_box_select,
    input  logic [10:0]        i_word_index,
    input  logic [63:0]        i_word_value,
    input  logic [63:0]        i_block_left,
    input  logic [63:0]        i_block_right,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [1:0]         i_result_kind,
    input  logic [63:0]        i_out_left,
    input  logic [63:0]        i_out_right,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int BOX_WORDS = 2048;
    localparam int ROUND_CNT = 16;

    typedef struct {
        t_kind kind;
        t_word left;
        t_word right;
    } t_cipher_result;

    t_word          p_words [P_DEPTH];
    t_word          sbox_mirror [NUM_BOXES*BOX_WORDS];
    t_word          key_regs [KEY_WORDS];
    t_word          data_regs [KEY_WORDS];
    logic [WORDS_W-1:0] box_words_cfg;
    t_cipher_result result_q [$];
    int             fail_cnt = 0;

    assign o_fail_count = fail_cnt;

    task automatic report(input string what);
        $display("[%0t] checker: %s", $time, what);
        fail_cnt++;
    endtask

    function automatic t_word ror64(input t_word v, input int n);
        return (v >> n) | (v << (64 - n));
    endfunction

    // Bit 0 of the count is dropped; the result is clamped to 2..BOX_WORDS.
    function automatic int live_words();
        int w;
        w = int'(box_words_cfg & 12'hFFE);
        if (w == 0) w = 2;
        if (w > BOX_WORDS) w = BOX_WORDS;
        return w;
    endfunction

    function automatic t_word box_lookup(input int b, input t_word v);
        t_word pos;
        pos = v % t_word'(live_words());
        return sbox_mirror[b*BOX_WORDS + int'(pos)];
    endfunction

    function automatic t_word mix(input t_word x);
        t_word h;
        h = box_lookup(0, ror64(x, 61)) + box_lookup(1, ror64(x, 22));
        h ^= box_lookup(2, ror64(x, 53));
        return h + box_lookup(3, ror64(x, 33));
    endfunction

    task automatic cipher_block(inout t_word l, inout t_word r);
        t_word tmp;
        for (int i = 0; i < ROUND_CNT; i += 2) begin
            l ^= p_words[i];
            r ^= mix(l);
            r ^= p_words[i+1];
            l ^= mix(r);
        end
        l ^= p_words[ROUND_CNT % P_DEPTH];
        r ^= p_words[(ROUND_CNT + 1) % P_DEPTH];
        tmp = l;
        l = r;
        r = tmp;
    endtask

    task automatic rekey();
        t_word l;
        t_word r;
        int    w;
        l = '0;
        r = '0;
        for (int i = 0; i < P_DEPTH; i++) p_words[i] ^= key_regs[i % KEY_WORDS];
        for (int i = 0; i < P_DEPTH; i += 2) begin
            l ^= data_regs[i % KEY_WORDS];
            r ^= data_regs[i % KEY_WORDS];
            cipher_block(l, r);
            p_words[i]   = l;
            p_words[i+1] = r;
        end
        w = live_words();
        for (int b = 0; b < NUM_BOXES; b++) begin
            for (int j = 0; j + 1 < w; j += 2) begin
                l ^= data_regs[j % KEY_WORDS];
                r ^= data_regs[j % KEY_WORDS];
                cipher_block(l, r);
                sbox_mirror[b*BOX_WORDS + j]     = l;
                sbox_mirror[b*BOX_WORDS + j + 1] = r;
            end
        end
    endtask

    task automatic clear_state();
        foreach (p_words[i]) p_words[i] = P_INIT[i];
        foreach (sbox_mirror[i]) sbox_mirror[i] = '0;
        foreach (key_regs[i]) key_regs[i] = '0;
        foreach (data_regs[i]) data_regs[i] = '0;
        box_words_cfg = WORDS_RESET;
    endtask

    always @(posedge i_clk) begin
        t_cipher_result e;
        t_cipher_result got;
        t_word l;
        t_word r;
        if (!i_rst_n) begin
            clear_state();
            result_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) box_words_cfg = i_cfg_wdata;
            if (i_out_valid && !i_out_stall) begin
                if (result_q.size() == 0) begin
                    report("result transaction with nothing outstanding");
                end else begin
                    e = result_q.pop_front();
                    if (i_result_kind !== e.kind)
                        report($sformatf("kind %0d, predicted %0d", i_result_kind, e.kind));
                    if (i_out_left !== e.left)
                        report($sformatf("left %h, predicted %h", i_out_left, e.left));
                    if (i_out_right !== e.right)
                        report($sformatf("right %h, predicted %h", i_out_right, e.right));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                got.kind  = KIND_LOAD_ACK;
                got.left  = '0;
                got.right = '0;
                case (i_cmd)
                    CMD_LOAD_SBOX: begin
                        sbox_mirror[i_box_select*BOX_WORDS + i_word_index] = i_word_value;
                    end
                    CMD_LOAD_P:    if (i_word_index < P_DEPTH) p_words[i_word_index] = i_word_value;
                    CMD_LOAD_KEY:  if (i_word_index < KEY_WORDS) key_regs[i_word_index] = i_word_value;
                    CMD_LOAD_DATA: if (i_word_index < KEY_WORDS) data_regs[i_word_index] = i_word_value;
                    CMD_EXPAND: begin
                        rekey();
                        got.kind = KIND_EXPANDED;
                    end
                    CMD_ENCIPHER: begin
                        l = i_block_left;
                        r = i_block_right;
                        cipher_block(l, r);
                        got.kind  = KIND_BLOCK;
                        got.left  = l;
                        got.right = r;
                    end
                    default: ;
                endcase
                result_q.push_back(got);
            end
            o_pending <= result_q.size();
        end
    end

endmodule

FILE: tb/tb_dynamic_sbox_feistel64_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_dynamic_sbox_feistel64_engine_unit
// Fills the low words of every S-box, runs directed corner cases and then
// random command streams under several word counts and handshake idling
// patterns. A separate checker predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_dynamic_sbox_feistel64_engine_unit;
    import dsf64_pkg::*;

    // Command codes the engine does not define; it must acknowledge them only.
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    // Well above the length of one expand at the small word counts, so it leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 120000;
    localparam int HOLD_CYCLES    = 600;
    localparam int SMALL_MAX      = 17;
    // Words written per box before any lookup; active word counts never exceed it.
    localparam int FILL_WORDS     = 64;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [WORDS_W-1:0] cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         cmd = '0;
    logic [1:0]         box_select = '0;
    logic [10:0]        word_index = '0;
    t_word              word_value = '0;
    t_word              block_left = '0;
    t_word              block_right = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         result_kind;
    t_word              out_left;
    t_word              out_right;
    int                 fail_count;
    int                 pending;

    int tx_pct = 0;
    int rx_pct = 0;
    bit hold_req = 1'b0;

    always #2 clk = ~clk;

    dynamic_sbox_feistel64_engine_unit u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_cmd         (cmd),
        .i_box_select  (box_select),
        .i_word_index  (word_index),
        .i_word_value  (word_value),
        .i_block_left  (block_left),
        .i_block_right (block_right),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_result_kind (result_kind),
        .o_out_left    (out_left),
        .o_out_right   (out_right)
    );

    dsf64_result_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_cmd         (cmd),
        .i_box_select  (box_select),
        .i_word_index  (word_index),
        .i_word_value  (word_value),
        .i_block_left  (block_left),
        .i_block_right (block_right),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_result_kind (result_kind),
        .i_out_left    (out_left),
        .i_out_right   (out_right),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // The result side stalls at random. When a hold is requested it stalls for
    // a long stretch, so the single pending result backs up into the command
    // channel while the sender keeps offering transactions.
    initial begin
        int  hold_left;
        bit  hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= (rx_pct > 0) && ($urandom_range(99) < rx_pct);
            end
        end
    end

    // Watchdog: any long stretch with no transaction on either channel means
    // the engine has hung, so the run stops there.
    always @(posedge clk) begin
        int quiet;
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic t_word rand64();
        return {$urandom, $urandom};
    endfunction

    // Offers one command transaction and returns at the edge that accepts it.
    // Valid stays high afterwards; the next call or a drain decides its fate.
    task automatic send(input logic [2:0] c, input logic [1:0] b, input logic [10:0] ix,
                        input t_word v, input t_word l, input t_word r);
        int gap;
        if (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
            in_valid <= 1'b0;
            gap = $urandom_range(4, 1);
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        box_select  <= b;
        word_index  <= ix;
        word_value  <= v;
        block_left  <= l;
        block_right <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_simple(input logic [2:0] c, input logic [10:0] ix, input t_word v);
        send(c, 2'($urandom), ix, v, rand64(), rand64());
    endtask

    // Drops valid and waits until every predicted result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // The word count is only written while the engine is idle.
    task automatic set_words(input logic [WORDS_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // A full rekey: fresh key and data words, expand, then a few blocks.
    task automatic rekey_sequence();
        for (int i = 0; i < KEY_WORDS; i++) send_simple(CMD_LOAD_KEY, 11'(i), rand64());
        for (int i = 0; i < KEY_WORDS; i++) send_simple(CMD_LOAD_DATA, 11'(i), rand64());
        send_simple(CMD_EXPAND, 11'($urandom), rand64());
        repeat ($urandom_range(3, 1)) send_simple(CMD_ENCIPHER, 11'($urandom), rand64());
    endtask

    // One random command or rekey sequence; expand only appears when the word count is small.
    task automatic random_command(input bit small_box);
        int          pick;
        logic [10:0] ix;
        pick = $urandom_range(99);
        ix   = $urandom_range(1) ? 11'($urandom) : 11'($urandom_range(20));
        if (small_box && pick < 3)
            rekey_sequence();
        else if (small_box && pick < 7)
            send_simple(CMD_EXPAND, ix, rand64());
        else if (pick < 40)
            send_simple(CMD_ENCIPHER, ix, rand64());
        else if (pick < 52)
            send_simple(CMD_LOAD_SBOX, 11'($urandom), rand64());
        else if (pick < 66)
            send_simple(CMD_LOAD_P, ix, rand64());
        else if (pick < 78)
            send_simple(CMD_LOAD_KEY, ix, rand64());
        else if (pick < 90)
            send_simple(CMD_LOAD_DATA, ix, rand64());
        else if (pick < 95)
            send_simple($urandom_range(1) ? CMD_SPARE_6 : CMD_SPARE_7, ix, rand64());
        else
            send_simple(CMD_ENCIPHER, ix, {64{pick[0]}});
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Write the low words of every S-box once. Every word count used below
        // stays within them, so no lookup can hit an unwritten entry.
        for (int b = 0; b < NUM_BOXES; b++)
            for (int j = 0; j < FILL_WORDS; j++)
                send(CMD_LOAD_SBOX, 2'(b), 11'(j), rand64(), rand64(), rand64());

        // Directed corners at the full filled count, then the smallest counts.
        set_words(12'(FILL_WORDS));
        send(CMD_ENCIPHER, 2'd0, 11'd0, '0, '0, '0);
        send(CMD_ENCIPHER, 2'd3, 11'h7FF, '1, '1, '1);
        set_words(12'd0);
        send(CMD_ENCIPHER, 2'd1, 11'd5, rand64(), rand64(), rand64());
        set_words(12'd1);
        send_simple(CMD_LOAD_P, 11'd0, '1);
        send_simple(CMD_LOAD_P, 11'd17, rand64());
        send_simple(CMD_LOAD_P, 11'd18, rand64());
        send_simple(CMD_LOAD_P, 11'h7FF, rand64());
        send_simple(CMD_LOAD_KEY, 11'd0, '1);
        send_simple(CMD_LOAD_KEY, 11'd7, rand64());
        send_simple(CMD_LOAD_KEY, 11'd8, rand64());
        send_simple(CMD_LOAD_DATA, 11'd7, '1);
        send_simple(CMD_LOAD_DATA, 11'd8, rand64());
        // A word beyond the count is kept but never used by the rounds.
        send(CMD_LOAD_SBOX, 2'd3, 11'h7FF, '1, '0, '0);
        send(CMD_LOAD_SBOX, 2'd0, 11'd0, '0, '1, '1);
        send_simple(CMD_SPARE_6, 11'd0, rand64());
        send_simple(CMD_SPARE_7, 11'h7FF, '1);
        send_simple(CMD_EXPAND, 11'd0, '0);
        send(CMD_ENCIPHER, 2'd0, 11'd0, '0, '0, '0);
        send(CMD_ENCIPHER, 2'd0, 11'd0, '0, '1, '1);
        // Odd counts drop bit 0.
        set_words(12'(FILL_WORDS + 1));
        send(CMD_ENCIPHER, 2'd2, 11'd1, rand64(), rand64(), rand64());
        set_words(12'd3);
        send(CMD_ENCIPHER, 2'd2, 11'd1, rand64(), rand64(), rand64());

        // Random streams: sender idles 30% and receiver 64%, then the other
        // way round, then neither. Each pattern runs a small count that allows
        // expand and a larger count that never expands.
        for (int phase = 0; phase < 3; phase++) begin
            set_words(12'($urandom_range(SMALL_MAX)));
            tx_pct = (phase == 0) ? 30 : (phase == 1) ? 64 : 0;
            rx_pct = (phase == 0) ? 64 : (phase == 1) ? 30 : 0;
            if (phase == 2) hold_req = 1'b1;
            repeat (35) random_command(1'b1);
            tx_pct = 0;
            rx_pct = 0;
            set_words((phase == 0) ? 12'(FILL_WORDS + 1)
                                   : 12'($urandom_range(FILL_WORDS, SMALL_MAX + 1)));
            tx_pct = (phase == 0) ? 30 : (phase == 1) ? 64 : 0;
            rx_pct = (phase == 0) ? 64 : (phase == 1) ? 30 : 0;
            repeat (30) random_command(1'b0);
            tx_pct = 0;
            rx_pct = 0;
        end

        drain();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/dsf64_pkg.sv
rtl/core/dynamic_sbox_feistel64_engine_unit.sv
tb/dsf64_result_checker.sv
tb/tb_dynamic_sbox_feistel64_engine_unit.sv
